// ===== rtl/core/dur_pkg.sv =====
// Shared types and constants for the dual ultrasonic ranger.
package dur_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TICKS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CM_PER_TICK  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEAR_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MID_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAR_LIMIT    = 3'd5;

   localparam logic [15:0] WINDOW_TICKS_RESET = 16'd65000;
   localparam logic [15:0] CM_PER_TICK_RESET  = 16'd17826;
   localparam logic [9:0]  NEAR_LIMIT_RESET   = 10'd15;
   localparam logic [9:0]  CLOSE_LIMIT_RESET  = 10'd50;
   localparam logic [9:0]  MID_LIMIT_RESET    = 10'd100;
   localparam logic [9:0]  FAR_LIMIT_RESET    = 10'd125;

   localparam logic [23:0] Q8_MAX      = 24'hFFFFFF;
   localparam logic [23:0] Q8_MIN_CM   = 24'd512;     // 2 cm
   localparam logic [23:0] Q8_MAX_CM   = 24'd102400;  // 400 cm

   localparam logic [1:0] STATUS_LOW  = 2'd0;
   localparam logic [1:0] STATUS_OK   = 2'd1;
   localparam logic [1:0] STATUS_HIGH = 2'd2;

   localparam logic [2:0] BARS_NEAR  = 3'd4;
   localparam logic [2:0] BARS_CLOSE = 3'd3;
   localparam logic [2:0] BARS_MID   = 3'd2;
   localparam logic [2:0] BARS_FAR   = 3'd1;
   localparam logic [2:0] BARS_NONE  = 3'd0;

   localparam logic [7:0] TOGGLES_NEAR  = 8'd200;
   localparam logic [7:0] TOGGLES_CLOSE = 8'd50;
   localparam logic [7:0] TOGGLES_MID   = 8'd10;
   localparam logic [7:0] TOGGLES_FAR   = 8'd5;
   localparam logic [7:0] TOGGLES_OFF   = 8'd0;

   typedef enum logic {
      PH_TRIGGER = 1'b0,
      PH_MEASURE = 1'b1
   } phase_type;

   typedef struct packed {
      logic trigger_pulse;
      logic measure_done;
   } flags_type;

   typedef struct packed {
      logic [9:0] near_limit_cm;
      logic [9:0] close_limit_cm;
      logic [9:0] mid_limit_cm;
      logic [9:0] far_limit_cm;
   } limits_type;

   typedef struct packed {
      logic        beep_fast;
      logic [7:0]  beep_toggles;
      logic        beep_on;
      logic [2:0]  back_bars;
      logic [2:0]  front_bars;
      logic [1:0]  back_status;
      logic [1:0]  front_status;
      logic [15:0] back_cm;
      logic [15:0] front_cm;
   } grade_type;

endpackage

// ===== rtl/core/dur_tick.sv =====
// Tick counter, trigger/measure phase control, echo counters and Q8 distance state.
module dur_tick #(
   parameter int unsigned CountWidth = dur_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               echo_front,
   input  logic               echo_back,
   input  logic [15:0]        window_ticks,
   input  logic [15:0]        cm_per_tick_q16,
   output dur_pkg::flags_type flags,
   output logic [23:0]        front_dist_q8,
   output logic [23:0]        back_dist_q8
);
   import dur_pkg::*;

   localparam int unsigned CmpWidth  = (CountWidth > 16) ? CountWidth : 16;
   localparam int unsigned ShWidth   = CountWidth + 8;
   localparam int unsigned SatWidth  = (ShWidth > 24) ? ShWidth : 24;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] tick_ff, tick_in, tick_inc;
   logic [CountWidth-1:0] fcnt_ff, fcnt_in;
   logic [CountWidth-1:0] bcnt_ff, bcnt_in;
   logic [23:0]           fq8_ff, fq8_in;
   logic [23:0]           bq8_ff, bq8_in;
   flags_type             flags_ff, flags_in;
   logic                  in_window;
   logic [23:0]           front_conv, back_conv;

   function automatic logic [23:0] to_q8(input logic [CountWidth-1:0] cnt,
                                         input logic [15:0] scale);
      logic [CountWidth+15:0] prod;
      logic [SatWidth-1:0]    sh;
      prod = {16'd0, cnt} * {{CountWidth{1'b0}}, scale};
      sh   = SatWidth'(prod[CountWidth+15:8]);
      return (sh > SatWidth'(Q8_MAX)) ? Q8_MAX : sh[23:0];
   endfunction

   function automatic logic [CountWidth-1:0] inc_sat(input logic [CountWidth-1:0] v);
      return (v == {CountWidth{1'b1}}) ? v : v + 1'b1;
   endfunction

   assign tick_inc   = tick_ff + 1'b1;
   assign in_window  = CmpWidth'(tick_inc) <= CmpWidth'(window_ticks);
   assign front_conv = to_q8(fcnt_ff, cm_per_tick_q16);
   assign back_conv  = to_q8(bcnt_ff, cm_per_tick_q16);

   // next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      fcnt_in  = fcnt_ff;
      bcnt_in  = bcnt_ff;
      fq8_in   = fq8_ff;
      bq8_in   = bq8_ff;
      if (accept) begin
         tick_in = tick_inc;
         unique case (phase_ff)
            PH_TRIGGER: begin
               phase_in = PH_MEASURE;
            end
            PH_MEASURE: begin
               if (in_window) begin
                  if (echo_front) fcnt_in = inc_sat(fcnt_ff);
                  if (echo_back)  bcnt_in = inc_sat(bcnt_ff);
               end else begin
                  tick_in  = '0;
                  fq8_in   = front_conv;
                  bq8_in   = back_conv;
                  fcnt_in  = '0;
                  bcnt_in  = '0;
                  phase_in = PH_TRIGGER;
               end
            end
            default: phase_in = PH_TRIGGER;
         endcase
      end
   end

   // outputs
   always_comb begin
      flags_in = flags_ff;
      if (accept) begin
         flags_in.trigger_pulse = (phase_ff == PH_TRIGGER);
         flags_in.measure_done  = (phase_ff == PH_MEASURE) && !in_window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIGGER;
         tick_ff  <= '0;
         fcnt_ff  <= '0;
         bcnt_ff  <= '0;
         fq8_ff   <= '0;
         bq8_ff   <= '0;
         flags_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         fcnt_ff  <= fcnt_in;
         bcnt_ff  <= bcnt_in;
         fq8_ff   <= fq8_in;
         bq8_ff   <= bq8_in;
         flags_ff <= flags_in;
      end
   end

   assign flags         = flags_ff;
   assign front_dist_q8 = fq8_ff;
   assign back_dist_q8  = bq8_ff;

endmodule

// ===== rtl/core/dur_grade.sv =====
// Distance grading: whole cm, range status, bar levels and beep selection.
module dur_grade (
   input  logic [23:0]         front_dist_q8,
   input  logic [23:0]         back_dist_q8,
   input  dur_pkg::limits_type limits,
   output dur_pkg::grade_type  grade
);
   import dur_pkg::*;

   logic [15:0] fcm, bcm, near_cm;

   function automatic logic [1:0] status_of(input logic [23:0] q8);
      if (q8 < Q8_MIN_CM)  return STATUS_LOW;
      if (q8 <= Q8_MAX_CM) return STATUS_OK;
      return STATUS_HIGH;
   endfunction

   function automatic logic [2:0] bars_of(input logic [23:0] q8, input limits_type lim);
      if (q8 <= {6'd0, lim.near_limit_cm, 8'd0})  return BARS_NEAR;
      if (q8 <= {6'd0, lim.close_limit_cm, 8'd0}) return BARS_CLOSE;
      if (q8 <= {6'd0, lim.mid_limit_cm, 8'd0})   return BARS_MID;
      if (q8 <= {6'd0, lim.far_limit_cm, 8'd0})   return BARS_FAR;
      return BARS_NONE;
   endfunction

   assign fcm     = front_dist_q8[23:8];
   assign bcm     = back_dist_q8[23:8];
   assign near_cm = (fcm < bcm) ? fcm : bcm;

   always_comb begin
      grade.front_cm     = fcm;
      grade.back_cm      = bcm;
      grade.front_status = status_of(front_dist_q8);
      grade.back_status  = status_of(back_dist_q8);
      grade.front_bars   = bars_of(front_dist_q8, limits);
      grade.back_bars    = bars_of(back_dist_q8, limits);
      grade.beep_on      = 1'b1;
      grade.beep_fast    = 1'b0;
      if (near_cm <= {6'd0, limits.near_limit_cm}) begin
         grade.beep_toggles = TOGGLES_NEAR;
         grade.beep_fast    = 1'b1;
      end else if (near_cm <= {6'd0, limits.close_limit_cm}) begin
         grade.beep_toggles = TOGGLES_CLOSE;
      end else if (near_cm <= {6'd0, limits.mid_limit_cm}) begin
         grade.beep_toggles = TOGGLES_MID;
      end else if (near_cm <= {6'd0, limits.far_limit_cm}) begin
         grade.beep_toggles = TOGGLES_FAR;
      end else begin
         grade.beep_toggles = TOGGLES_OFF;
         grade.beep_on      = 1'b0;
      end
   end

endmodule

// ===== rtl/core/dual_ultrasonic_ranger.sv =====
// Top level of the dual ultrasonic ranger: register file, pipeline control, result register.
//
//   channel  direction  carries
//   req_     in         one 16 us tick with both echo levels
//   rsp_     out        one result per tick: trigger, done, distances, status, bars, beep
//   csr_     in         register write, index and data, always ready
//
// Two register stages: the tick/counter stage and the result register. One tick per cycle
// unless rsp stalls; a tick goes through the tick/counter stage, then the result register.
// Synchronous reset clears phase, counters, distances and valid flags. A stalled rsp holds
// the result; req_tready drops only when both stages hold data and rsp is stalled.
module dual_ultrasonic_ranger #(
   parameter int unsigned COUNT_WIDTH = dur_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // echo_front, echo_back, pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // trigger_pulse, measure_done, front_cm, back_cm, front_status, back_status,
   // front_bars, back_bars, beep_on, beep_toggles, beep_fast, pad
   output logic [55:0]                           rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dur_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dur_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import dur_pkg::*;

   logic        accept, advance;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic [15:0] window_ff, scale_ff;
   limits_type  limits_ff;
   flags_type   flags;
   logic [23:0] front_dist_q8, back_dist_q8;
   grade_type   grade;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff                <= WINDOW_TICKS_RESET;
         scale_ff                 <= CM_PER_TICK_RESET;
         limits_ff.near_limit_cm  <= NEAR_LIMIT_RESET;
         limits_ff.close_limit_cm <= CLOSE_LIMIT_RESET;
         limits_ff.mid_limit_cm   <= MID_LIMIT_RESET;
         limits_ff.far_limit_cm   <= FAR_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_TICKS: window_ff                <= csr_data;
            CSR_CM_PER_TICK:  scale_ff                 <= csr_data;
            CSR_NEAR_LIMIT:   limits_ff.near_limit_cm  <= csr_data[9:0];
            CSR_CLOSE_LIMIT:  limits_ff.close_limit_cm <= csr_data[9:0];
            CSR_MID_LIMIT:    limits_ff.mid_limit_cm   <= csr_data[9:0];
            CSR_FAR_LIMIT:    limits_ff.far_limit_cm   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   dur_tick #(
      .CountWidth(COUNT_WIDTH)
   ) u_tick (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .echo_front      (req_tdata[0]),
      .echo_back       (req_tdata[1]),
      .window_ticks    (window_ff),
      .cm_per_tick_q16 (scale_ff),
      .flags           (flags),
      .front_dist_q8   (front_dist_q8),
      .back_dist_q8    (back_dist_q8)
   );

   dur_grade u_grade (
      .front_dist_q8 (front_dist_q8),
      .back_dist_q8  (back_dist_q8),
      .limits        (limits_ff),
      .grade         (grade)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            rsp_data_in = {2'b00, grade.beep_fast, grade.beep_toggles, grade.beep_on,
                           grade.back_bars, grade.front_bars, grade.back_status,
                           grade.front_status, grade.back_cm, grade.front_cm,
                           flags.measure_done, flags.trigger_pulse};
         end
      end
      if (accept) s1_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the dual ultrasonic ranger: tick stream in, per-tick result out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dur_pkg::*;

   localparam int unsigned RANDOM_TICKS = 800;
   localparam int unsigned RANDOM_SLACK = 100;
   localparam longint unsigned CYCLE_LIMIT = 600000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [15:0] HITS_MAX = 16'hFFFF;

   typedef struct packed {
      logic        trigger_pulse;
      logic        measure_done;
      logic [15:0] front_cm;
      logic [15:0] back_cm;
      logic [1:0]  front_status;
      logic [1:0]  back_status;
      logic [2:0]  front_bars;
      logic [2:0]  back_bars;
      logic        beep_on;
      logic [7:0]  beep_toggles;
      logic        beep_fast;
   } tick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   dual_ultrasonic_ranger dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // pending echo pairs (bit 0 front, bit 1 back) and expected tick results
   logic [1:0]      echo_q[$];
   tick_result_type tick_results_q[$];

   int unsigned fail_count = 0;
   int unsigned ticks_checked = 0;
   int unsigned windows_closed = 0;
   int unsigned reg_writes = 0;
   int unsigned directed_ticks = 0;
   int unsigned random_ticks = 0;
   longint unsigned cycles = 0;

   // ranger mirror: registers and state
   logic [15:0] window_ticks;
   logic [15:0] cm_per_tick;
   limits_type  limits;
   phase_type   phase;
   logic [15:0] tick_cnt, front_hits, back_hits;
   logic [23:0] front_q8, back_q8;

   function automatic logic [23:0] hits_to_q8(input logic [15:0] hits);
      logic [31:0] prod;
      prod = {16'd0, hits} * {16'd0, cm_per_tick};
      // a 16x16 product shifted by 8 always fits in 24 bits
      return prod[31:8];
   endfunction

   function automatic logic [1:0] range_status(input logic [23:0] q8);
      if (q8 < Q8_MIN_CM) return STATUS_LOW;
      if (q8 <= Q8_MAX_CM) return STATUS_OK;
      return STATUS_HIGH;
   endfunction

   function automatic logic [2:0] bar_level(input logic [23:0] q8);
      if (q8 <= {limits.near_limit_cm, 8'd0}) return BARS_NEAR;
      if (q8 <= {limits.close_limit_cm, 8'd0}) return BARS_CLOSE;
      if (q8 <= {limits.mid_limit_cm, 8'd0}) return BARS_MID;
      if (q8 <= {limits.far_limit_cm, 8'd0}) return BARS_FAR;
      return BARS_NONE;
   endfunction

   function automatic tick_result_type range_tick(input logic [1:0] echo);
      tick_result_type r;
      logic [15:0] nearest;
      r = '0;
      tick_cnt = tick_cnt + 16'd1;
      if (phase == PH_TRIGGER) begin
         r.trigger_pulse = 1'b1;
         phase = PH_MEASURE;
      end else if (tick_cnt <= window_ticks) begin
         if (echo[0] && front_hits != HITS_MAX) front_hits = front_hits + 16'd1;
         if (echo[1] && back_hits != HITS_MAX) back_hits = back_hits + 16'd1;
      end else begin
         tick_cnt = '0;
         front_q8 = hits_to_q8(front_hits);
         back_q8 = hits_to_q8(back_hits);
         front_hits = '0;
         back_hits = '0;
         phase = PH_TRIGGER;
         r.measure_done = 1'b1;
      end
      r.front_cm = front_q8[23:8];
      r.back_cm = back_q8[23:8];
      nearest = (r.front_cm < r.back_cm) ? r.front_cm : r.back_cm;
      r.beep_toggles = TOGGLES_OFF;
      if (nearest <= limits.near_limit_cm) begin
         r.beep_toggles = TOGGLES_NEAR;
         r.beep_fast = 1'b1;
         r.beep_on = 1'b1;
      end else if (nearest <= limits.close_limit_cm) begin
         r.beep_toggles = TOGGLES_CLOSE;
         r.beep_on = 1'b1;
      end else if (nearest <= limits.mid_limit_cm) begin
         r.beep_toggles = TOGGLES_MID;
         r.beep_on = 1'b1;
      end else if (nearest <= limits.far_limit_cm) begin
         r.beep_toggles = TOGGLES_FAR;
         r.beep_on = 1'b1;
      end
      r.front_status = range_status(front_q8);
      r.back_status = range_status(back_q8);
      r.front_bars = bar_level(front_q8);
      r.back_bars = bar_level(back_q8);
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result(input tick_result_type want, input logic [55:0] data);
      check_field("trigger_pulse", want.trigger_pulse, data[0]);
      check_field("measure_done", want.measure_done, data[1]);
      check_field("front_cm", want.front_cm, data[17:2]);
      check_field("back_cm", want.back_cm, data[33:18]);
      check_field("front_status", want.front_status, data[35:34]);
      check_field("back_status", want.back_status, data[37:36]);
      check_field("front_bars", want.front_bars, data[40:38]);
      check_field("back_bars", want.back_bars, data[43:41]);
      check_field("beep_on", want.beep_on, data[44]);
      check_field("beep_toggles", want.beep_toggles, data[52:45]);
      check_field("beep_fast", want.beep_fast, data[53]);
   endtask

   // monitor: register writes, result checks, prediction per accepted tick
   always @(posedge clock) begin
      if (reset) begin
         window_ticks = WINDOW_TICKS_RESET;
         cm_per_tick = CM_PER_TICK_RESET;
         limits = {NEAR_LIMIT_RESET, CLOSE_LIMIT_RESET, MID_LIMIT_RESET, FAR_LIMIT_RESET};
         phase = PH_TRIGGER;
         tick_cnt = '0;
         front_hits = '0;
         back_hits = '0;
         front_q8 = '0;
         back_q8 = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_TICKS: window_ticks = csr_data;
               CSR_CM_PER_TICK:  cm_per_tick = csr_data;
               CSR_NEAR_LIMIT:   limits.near_limit_cm = csr_data[9:0];
               CSR_CLOSE_LIMIT:  limits.close_limit_cm = csr_data[9:0];
               CSR_MID_LIMIT:    limits.mid_limit_cm = csr_data[9:0];
               CSR_FAR_LIMIT:    limits.far_limit_cm = csr_data[9:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tick_results_q.size() == 0) begin
               $error("result transfer with no tick pending: %h", rsp_tdata);
               fail_count++;
            end else begin
               check_result(tick_results_q.pop_front(), rsp_tdata);
               ticks_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            tick_results_q.push_back(range_tick(req_tdata[1:0]));
            if (tick_results_q[$].measure_done) windows_closed++;
         end
      end
   end

   // sender: bursts with random gaps
   int unsigned burst_left = 4;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (echo_q.size() > 0) begin
            req_tdata <= {6'd0, echo_q.pop_front()};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern re-chosen whenever the low six bits of the cycle counter are zero
   logic [7:0] stall_pattern = 8'hFF;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles[5:0] == 6'd0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end
      rsp_tready <= stall_pattern[cycles[2:0]];
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ticks outstanding", cycles, tick_results_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   // sampled on the falling edge so that all updates of the rising edge have settled
   task automatic wait_idle();
      @(negedge clock);
      while (echo_q.size() > 0 || req_tvalid || tick_results_q.size() > 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_ticks(input int unsigned n, input int unsigned front_pct,
                             input int unsigned back_pct);
      logic [1:0] e;
      for (int unsigned i = 0; i < n; i++) begin
         e[0] = $urandom_range(0, 99) < front_pct;
         e[1] = $urandom_range(0, 99) < back_pct;
         echo_q.push_back(e);
      end
   endtask

   function automatic int unsigned echo_density();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 100 : 0;
      return $urandom_range(0, 100);
   endfunction

   task automatic randomize_limits(input int unsigned span);
      logic [9:0] v [4];
      logic [9:0] t;
      int unsigned style;
      style = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         case (style)
            0, 1: v[i] = 10'($urandom_range(0, span));
            2: v[i] = 10'($urandom_range(0, 1023));
            default: v[i] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
         endcase
      end
      if (style <= 1) begin
         for (int p = 0; p < 3; p++)
            for (int i = 0; i < 3 - p; i++)
               if (v[i] > v[i+1]) begin
                  t = v[i];
                  v[i] = v[i+1];
                  v[i+1] = t;
               end
      end
      write_reg(CSR_NEAR_LIMIT, {6'd0, v[0]});
      write_reg(CSR_CLOSE_LIMIT, {6'd0, v[1]});
      write_reg(CSR_MID_LIMIT, {6'd0, v[2]});
      write_reg(CSR_FAR_LIMIT, {6'd0, v[3]});
   endtask

   initial begin
      int unsigned w, scale, n, span;
      int unsigned sel;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset registers, every echo combination
      echo_q.push_back(2'b00);
      echo_q.push_back(2'b01);
      echo_q.push_back(2'b10);
      echo_q.push_back(2'b11);
      echo_q.push_back(2'b11);
      directed_ticks += 5;
      wait_idle();

      // short window, full scale, tight limits
      write_reg(CSR_WINDOW_TICKS, 16'd3);
      write_reg(CSR_CM_PER_TICK, 16'hFFFF);
      write_reg(CSR_NEAR_LIMIT, 16'd0);
      write_reg(CSR_CLOSE_LIMIT, 16'd1);
      write_reg(CSR_MID_LIMIT, 16'd2);
      write_reg(CSR_FAR_LIMIT, 16'd3);
      push_ticks(7, 100, 100);
      directed_ticks += 7;
      wait_idle();

      // one-tick window, zero scale, writes to unused indexes
      write_reg(CSR_WINDOW_TICKS, 16'd1);
      write_reg(CSR_CM_PER_TICK, 16'd0);
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'hFFFF);
      push_ticks(5, 50, 50);
      directed_ticks += 5;
      wait_idle();

      // window that never closes, all limits at maximum
      write_reg(CSR_WINDOW_TICKS, 16'hFFFF);
      write_reg(CSR_CM_PER_TICK, 16'hFFFF);
      write_reg(CSR_NEAR_LIMIT, 16'h03FF);
      write_reg(CSR_CLOSE_LIMIT, 16'h03FF);
      write_reg(CSR_MID_LIMIT, 16'h03FF);
      write_reg(CSR_FAR_LIMIT, 16'h03FF);
      push_ticks(6, 100, 0);
      directed_ticks += 6;

      while (random_ticks < RANDOM_TICKS) begin
         wait_idle();
         sel = $urandom_range(0, 9);
         if (sel < 6) w = $urandom_range(1, 40);
         else if (sel < 9) w = $urandom_range(41, 300);
         else w = $urandom_range(301, 1200);
         sel = $urandom_range(0, 7);
         if (sel == 0) scale = 0;
         else if (sel == 1) scale = 16'hFFFF;
         else scale = $urandom_range(0, 16'hFFFF);
         write_reg(CSR_WINDOW_TICKS, w[15:0]);
         write_reg(CSR_CM_PER_TICK, scale[15:0]);
         span = (w * scale) >> 16;
         span = span + span / 4 + 2;
         if (span > 1023) span = 1023;
         if ($urandom_range(0, 2) != 0) randomize_limits(span);
         if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
         n = $urandom_range(w + 2, 2 * w + 8);
         if (random_ticks + n > RANDOM_TICKS + RANDOM_SLACK)
            n = RANDOM_TICKS + RANDOM_SLACK - random_ticks;
         push_ticks(n, echo_density(), echo_density());
         random_ticks += n;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("ticks checked: %0d (%0d directed, %0d random), windows closed: %0d",
               ticks_checked, directed_ticks, random_ticks, windows_closed);
      $display("register writes: %0d, cycles: %0d", reg_writes, cycles);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dur_pkg.sv
rtl/core/dur_tick.sv
rtl/core/dur_grade.sv
rtl/core/dual_ultrasonic_ranger.sv
test/tb.sv
